[rtl/core/iba_pkg.sv]
// Shared constants, payload types and codes of the indexed block allocator.
`default_nettype none
package iba_pkg;

  localparam int DISK_BLOCKS = 64;
  localparam int MAX_FILES   = 16;
  localparam int ID_BITS     = 16;

  localparam int BLK_BITS  = $clog2(DISK_BLOCKS);
  localparam int SLOT_BITS = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int SCAN_MAX  = (DISK_BLOCKS > MAX_FILES) ? DISK_BLOCKS : MAX_FILES;
  localparam int SCAN_BITS = $clog2(SCAN_MAX + 1);

  localparam logic [6:0] DISK_SIZE_RST = 7'd64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] MAP_FREE  = 2'd0;
  localparam logic [1:0] MAP_DATA  = 2'd1;
  localparam logic [1:0] MAP_INDEX = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_TOO_BIG  = 3'd2;
  localparam logic [2:0] ST_NO_INDEX = 3'd3;
  localparam logic [2:0] ST_NO_SPACE = 3'd4;
  localparam logic [2:0] ST_MISSING  = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  typedef struct packed {
    logic        op;
    logic [15:0] file_id;
    logic [7:0]  file_size;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] index_block;
    logic [6:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic [ID_BITS-1:0]     key;
    logic [BLK_BITS-1:0]    idx_blk;
    logic [DISK_BLOCKS-1:0] data_map;
  } entry_t;

endpackage
`default_nettype wire

[rtl/core/iba_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module iba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/indexed_block_allocator.sv]
// Top level of the indexed block allocator: request sequencer around two RAMs.
//
// Requests arrive on in_valid/in_stall with in_data (op, file_id, file_size);
// one result per request leaves on out_valid/out_stall with out_data (status,
// index_block, free_count). A transaction completes when valid is high and
// stall is low. cfg_wr_en/cfg_wr_data write the disk size register.
// One request is worked at a time. Each request scans the file table RAM
// and counts free blocks in the block map RAM; an accepted allocate or
// deallocate then sweeps the block map again, reading and writing back one
// block a cycle. A rejected request offers its result after the count, a
// successful one after the second sweep and the table update; the next
// request can be accepted in the cycle after the result is loaded. The
// sweeps over the single block map read port set the request rate.
// The result waits in an output register, so the next request is taken
// while a stalled result is still held; only a second finished result waits
// for the first to leave. Reset clears the block map valid bits (every block
// reads free), empties the file table and sets the disk size to 64.
`default_nettype none
module indexed_block_allocator
  import iba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [6:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire req_t       in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output rsp_t            out_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TAB  = 7'b0000010,
    S_CNT  = 7'b0000100,
    S_DEC  = 7'b0001000,
    S_MOD  = 7'b0010000,
    S_WRT  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state;
  req_t   req;
  rsp_t   res;

  logic [6:0]             disk_size;
  logic [SCAN_BITS-1:0]   cnt;
  logic                   pend;
  logic [SCAN_BITS-1:0]   paddr;
  logic                   found;
  logic [SLOT_BITS-1:0]   fslot;
  logic [BLK_BITS-1:0]    fidx;
  logic [DISK_BLOCKS-1:0] fmap;
  logic [6:0]             nfree;
  logic                   have_idx;
  logic [7:0]             taken;
  logic [BLK_BITS-1:0]    idx_reg;
  logic [DISK_BLOCKS-1:0] dmap;
  logic [DISK_BLOCKS-1:0] bvld;
  logic [MAX_FILES-1:0]   fvld;
  logic                   rd_ok;

  logic                map_we;
  logic [BLK_BITS-1:0] map_waddr;
  logic [1:0]          map_wdata;
  logic [BLK_BITS-1:0] map_raddr;
  logic [1:0]          map_rdata;

  logic                 tab_we;
  logic [SLOT_BITS-1:0] tab_raddr;
  entry_t               tab_wdata;
  entry_t               tab_rdata;

  logic [6:0]          lim;
  logic [1:0]          blk_old;
  logic                in_lim;
  logic                tab_hit;
  logic                take_idx;
  logic                take_dat;
  logic                cnt_free;
  logic                has_slot;
  logic [SLOT_BITS-1:0] free_slot;
  logic [BLK_BITS-1:0]  pblk;
  logic                 dec_go;
  logic [2:0]           dec_status;

  iba_ram #(.WIDTH(2), .DEPTH(DISK_BLOCKS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  iba_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_FILES)) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (free_slot),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign map_raddr = cnt[BLK_BITS-1:0];
  assign tab_raddr = cnt[SLOT_BITS-1:0];
  assign pblk      = paddr[BLK_BITS-1:0];
  assign lim       = (disk_size > 7'(DISK_BLOCKS)) ? 7'(DISK_BLOCKS) : disk_size;
  // A block never written since reset reads as free.
  assign blk_old   = rd_ok ? map_rdata : MAP_FREE;
  assign in_lim    = ({{(7 - BLK_BITS){1'b0}}, pblk} < lim);
  assign tab_hit   = pend && fvld[paddr[SLOT_BITS-1:0]] &&
                     (tab_rdata.key == req.file_id[ID_BITS-1:0]);
  assign tab_we    = (state == S_WRT) && (req.op == OP_ALLOC);
  assign tab_wdata = '{key: req.file_id[ID_BITS-1:0], idx_blk: idx_reg, data_map: dmap};

  always_comb begin
    has_slot  = 1'b0;
    free_slot = '0;
    for (int e = MAX_FILES - 1; e >= 0; e--) begin
      if (!fvld[e]) begin
        has_slot  = 1'b1;
        free_slot = SLOT_BITS'(e);
      end
    end
  end

  // Checks are taken in order; the first that fails gives the status.
  always_comb begin
    dec_go     = 1'b0;
    dec_status = ST_OK;
    if (req.op == OP_ALLOC) begin
      if (found) begin
        dec_status = ST_DUP;
      end else if (({1'b0, req.file_size} + 9'd1) > {2'b00, lim}) begin
        dec_status = ST_TOO_BIG;
      end else if (nfree == '0) begin
        dec_status = ST_NO_INDEX;
      end else if (({1'b0, nfree} - 8'd1) < req.file_size) begin
        dec_status = ST_NO_SPACE;
      end else if (!has_slot) begin
        dec_status = ST_FULL;
      end else begin
        dec_go = 1'b1;
      end
    end else begin
      if (!found) begin
        dec_status = ST_MISSING;
      end else begin
        dec_go = 1'b1;
      end
    end
  end

  // Read-modify-write of the block map: block n is written while block n+1 is read.
  always_comb begin
    map_we    = 1'b0;
    map_waddr = pblk;
    map_wdata = MAP_FREE;
    take_idx  = 1'b0;
    take_dat  = 1'b0;
    cnt_free  = 1'b0;
    if ((state == S_MOD) && pend) begin
      if (req.op == OP_ALLOC) begin
        if ((blk_old == MAP_FREE) && in_lim) begin
          if (!have_idx) begin
            take_idx = 1'b1;
          end else if (taken < req.file_size) begin
            take_dat = 1'b1;
          end else begin
            cnt_free = 1'b1;
          end
        end
        map_we    = take_idx | take_dat;
        map_wdata = take_idx ? MAP_INDEX : MAP_DATA;
      end else begin
        if ((pblk == fidx) || fmap[pblk]) begin
          map_we   = 1'b1;
          cnt_free = in_lim;
        end else begin
          cnt_free = (blk_old == MAP_FREE) && in_lim;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      disk_size <= DISK_SIZE_RST;
      bvld      <= '0;
      fvld      <= '0;
      pend      <= 1'b0;
      rd_ok     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        disk_size <= cfg_wr_data;
      end
      rd_ok <= bvld[map_raddr];
      if (map_we) begin
        bvld[map_waddr] <= 1'b1;
      end
      // The finishing state loads or holds the output register itself.
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            cnt   <= '0;
            pend  <= 1'b0;
            found <= 1'b0;
            state <= S_TAB;
          end
        end
        S_TAB: begin
          if (tab_hit && !found) begin
            found <= 1'b1;
            fslot <= paddr[SLOT_BITS-1:0];
            fidx  <= tab_rdata.idx_blk;
            fmap  <= tab_rdata.data_map;
          end
          if (cnt < SCAN_BITS'(MAX_FILES)) begin
            pend  <= 1'b1;
            paddr <= cnt;
            cnt   <= cnt + 1'b1;
          end else begin
            pend  <= 1'b0;
            cnt   <= '0;
            nfree <= '0;
            state <= S_CNT;
          end
        end
        S_CNT: begin
          if (pend && (blk_old == MAP_FREE) && in_lim) begin
            nfree <= nfree + 1'b1;
          end
          if (cnt < SCAN_BITS'(DISK_BLOCKS)) begin
            pend  <= 1'b1;
            paddr <= cnt;
            cnt   <= cnt + 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          cnt      <= '0;
          have_idx <= 1'b0;
          taken    <= '0;
          dmap     <= '0;
          res.status      <= dec_status;
          res.index_block <= '0;
          res.free_count  <= nfree;
          if (dec_go) begin
            nfree <= '0;
            state <= S_MOD;
          end else begin
            state <= S_FIN;
          end
        end
        S_MOD: begin
          if (take_idx) begin
            have_idx <= 1'b1;
            idx_reg  <= pblk;
          end
          if (take_dat) begin
            taken      <= taken + 1'b1;
            dmap[pblk] <= 1'b1;
          end
          if (cnt_free) begin
            nfree <= nfree + 1'b1;
          end
          if (cnt < SCAN_BITS'(DISK_BLOCKS)) begin
            pend  <= 1'b1;
            paddr <= cnt;
            cnt   <= cnt + 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_WRT;
          end
        end
        S_WRT: begin
          res.status     <= ST_OK;
          res.free_count <= nfree;
          if (req.op == OP_ALLOC) begin
            fvld[free_slot] <= 1'b1;
            res.index_block <= 6'(idx_reg);
          end else begin
            fvld[fslot]     <= 1'b0;
            res.index_block <= 6'(fidx);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/indexed_block_allocator_test.sv]
// Self-checking testbench for the indexed block allocator.
`timescale 1ns / 100ps
`default_nettype none
module indexed_block_allocator_test;
  import iba_pkg::*;

  class alloc_scoreboard;
    logic [1:0]  blk_mark [DISK_BLOCKS];
    bit          slot_used [MAX_FILES];
    logic [15:0] slot_key [MAX_FILES];
    logic [5:0]  slot_idx [MAX_FILES];
    logic [63:0] slot_data [MAX_FILES];
    int unsigned disk_size;
    rsp_t        pending[$];
    int          errors;

    function new();
      foreach (blk_mark[i]) blk_mark[i] = MAP_FREE;
      foreach (slot_used[i]) slot_used[i] = 0;
      disk_size = 64;
      errors = 0;
    endfunction

    function int unsigned usable();
      return (disk_size > DISK_BLOCKS) ? DISK_BLOCKS : disk_size;
    endfunction

    function int unsigned free_blocks();
      int unsigned n;
      n = 0;
      for (int i = 0; i < usable(); i++) if (blk_mark[i] == MAP_FREE) n++;
      return n;
    endfunction

    function void note_request(req_t rq);
      rsp_t r;
      int hit, slot;
      int unsigned lim, nfree, taken;
      bit got_idx;
      r = '0;
      hit = -1;
      slot = -1;
      lim = usable();
      for (int e = 0; e < MAX_FILES; e++)
        if (slot_used[e] && slot_key[e] == rq.file_id && hit < 0) hit = e;
      if (rq.op == OP_ALLOC) begin
        if (hit >= 0) r.status = ST_DUP;
        else if (rq.file_size + 1 > lim) r.status = ST_TOO_BIG;
        else begin
          nfree = free_blocks();
          for (int s = 0; s < MAX_FILES; s++) if (!slot_used[s] && slot < 0) slot = s;
          if (nfree == 0) r.status = ST_NO_INDEX;
          else if (nfree - 1 < rq.file_size) r.status = ST_NO_SPACE;
          else if (slot < 0) r.status = ST_FULL;
          else begin
            taken = 0;
            got_idx = 0;
            slot_data[slot] = '0;
            for (int i = 0; i < lim; i++) begin
              if (blk_mark[i] != MAP_FREE) continue;
              if (!got_idx) begin
                got_idx = 1;
                r.index_block = 6'(i);
                blk_mark[i] = MAP_INDEX;
              end else if (taken < rq.file_size) begin
                blk_mark[i] = MAP_DATA;
                slot_data[slot][i] = 1'b1;
                taken++;
              end
            end
            slot_used[slot] = 1;
            slot_key[slot] = rq.file_id;
            slot_idx[slot] = r.index_block;
          end
        end
      end else begin
        if (hit < 0) r.status = ST_MISSING;
        else begin
          r.index_block = slot_idx[hit];
          blk_mark[slot_idx[hit]] = MAP_FREE;
          for (int i = 0; i < DISK_BLOCKS; i++) if (slot_data[hit][i]) blk_mark[i] = MAP_FREE;
          slot_used[hit] = 0;
        end
      end
      if (r.status != ST_OK) r.index_block = '0;
      r.free_count = 7'(free_blocks());
      pending = {pending, r};
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $error("result with nothing outstanding: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
      if (got.index_block !== want.index_block) begin
        $error("index_block expected %0d actual %0d", want.index_block, got.index_block);
        errors++;
      end
      if (got.free_count !== want.free_count) begin
        $error("free_count expected %0d actual %0d", want.free_count, got.free_count);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_wr_en;
  logic [6:0] cfg_wr_data;
  logic in_valid, in_stall, out_valid, out_stall;
  req_t in_data;
  rsp_t out_data;

  alloc_scoreboard sb;
  int idle_pct;        // chance in a hundred that a side idles
  bit hold_output;     // receiver long hold-off request
  int quiet_cycles;
  logic [15:0] live_ids[$];

  indexed_block_allocator u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long counted hold-off when asked.
  initial begin
    int hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall && !rst) sb.check_result(out_data);
      if (hold_output && hold == 0) hold = 600;
      if (hold > 0) begin
        hold--;
        if (hold == 0) hold_output = 0;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 5000) begin
        $display("indexed_block_allocator_test failed");
        $finish;
      end
    end
  end

  // Valid stays high after a transaction until the next call drives it.
  task automatic send(input logic op, input logic [15:0] id, input logic [7:0] size);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= '{op: op, file_id: id, file_size: size};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(in_data);
    if (op == OP_ALLOC) live_ids = {live_ids, id};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_disk_size(input logic [6:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.disk_size = v;
  endtask

  task automatic random_item(input int max_size);
    logic [15:0] id;
    int pick;
    pick = $urandom_range(99);
    if (live_ids.size() != 0 && pick < 40)
      id = live_ids[$urandom_range(live_ids.size() - 1)];
    else if (pick < 90) id = 16'($urandom_range(31));
    else id = 16'($urandom);
    if ($urandom_range(99) < 45) send(OP_FREE, id, 8'($urandom));
    else if ($urandom_range(19) == 0) send(OP_ALLOC, id, 8'($urandom));
    else send(OP_ALLOC, id, 8'($urandom_range(max_size)));
  endtask

  initial begin
    int sizes[6];
    sb = new();
    idle_pct = 37;
    hold_output = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, duplicates, missing files, full disk and full table.
    send(OP_ALLOC, 16'hFFFF, 8'd0);
    send(OP_ALLOC, 16'hFFFF, 8'd3);
    send(OP_ALLOC, 16'h0000, 8'd255);
    send(OP_ALLOC, 16'h0000, 8'd63);
    send(OP_ALLOC, 16'h0001, 8'd62);
    send(OP_FREE, 16'h1234, 8'hFF);
    send(OP_ALLOC, 16'h0002, 8'd0);
    send(OP_FREE, 16'hFFFF, 8'd0);
    send(OP_ALLOC, 16'h0003, 8'd1);
    send(OP_FREE, 16'h0001, 8'd0);
    for (int i = 0; i < 17; i++) send(OP_ALLOC, 16'(16'h0100 + i), 8'd0);
    for (int i = 0; i < 17; i++) send(OP_FREE, 16'(16'h0100 + i), 8'd0);
    send(OP_FREE, 16'h0002, 8'd0);
    send(OP_FREE, 16'h0003, 8'd0);
    set_disk_size(7'd0);
    send(OP_ALLOC, 16'h0005, 8'd0);
    set_disk_size(7'd127);
    send(OP_ALLOC, 16'h0005, 8'd63);
    set_disk_size(7'd1);
    send(OP_ALLOC, 16'h0006, 8'd0);
    send(OP_FREE, 16'h0005, 8'd0);
    send(OP_ALLOC, 16'h0006, 8'd0);

    // Receiver holds off while requests keep coming; then the sender pauses.
    set_disk_size(7'd64);
    hold_output = 1;
    for (int i = 0; i < 6; i++) random_item(6);
    drain();

    sizes = '{64, 20, 8, 40, 1, 100};
    foreach (sizes[p]) begin
      set_disk_size(7'(sizes[p]));
      idle_pct = (p == 2) ? 0 : 37;
      for (int i = 0; i < 170; i++) random_item((p == 5) ? 10 : 6);
    end

    drain();
    if (sb.errors == 0) $display("indexed_block_allocator_test passed");
    else $display("indexed_block_allocator_test failed");
    $finish;
  end
endmodule
`default_nettype wire
